FILE: design/mpsq_pkg.sv
// Package with shared constants and types of the masked pending signal queue.
package mpsq_pkg;

    // Default number of queue entries.
    localparam int DEFAULT_QUEUE_DEPTH = 32;

    // Field widths.
    localparam int SIG_W   = 4;
    localparam int MASK_W  = 16;
    localparam int TAKEN_W = 5;
    localparam int OCC_W   = 6;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    // Returned when no signal is removed.
    localparam logic [TAKEN_W-1:0] NO_SIGNAL = 5'd16;

    // Per-cell control from the top level.
    typedef struct packed {
        logic occupied;
        logic load;
        logic take;
    } t_cell_ctl;

    // Search chain passed from the older cell to the younger one.
    typedef struct packed {
        logic             found;
        logic [SIG_W-1:0] sig;
    } t_chain;

endpackage

FILE: design/mpsq_cell.sv
// One queue slot: holds a signal number, joins the first-unblocked search and shifts.
module mpsq_cell
    import mpsq_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [MASK_W-1:0] i_mask,
    input  logic [SIG_W-1:0]  i_ins_sig,
    input  logic [SIG_W-1:0]  i_next_sig,
    input  t_chain            i_chain,
    output t_chain            o_chain,
    output logic [SIG_W-1:0]  o_sig
);

    logic [SIG_W-1:0] r_sig;
    logic             eligible;

    // This slot qualifies when it holds an entry whose signal is not blocked.
    assign eligible = i_ctl.occupied && !i_mask[r_sig];

    // The oldest eligible slot wins; later slots pass its number along.
    always_comb begin
        o_chain.found = i_chain.found | eligible;
        o_chain.sig   = i_chain.found ? i_chain.sig : r_sig;
    end

    assign o_sig = r_sig;

    // Load at the tail on insert, or take the younger neighbor's entry from the hit on.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sig <= i_ins_sig;
        end else if (i_ctl.take && o_chain.found) begin
            r_sig <= i_next_sig;
        end
    end

endmodule

FILE: design/masked_pending_signal_queue_unit.sv
// Top level of the masked pending signal queue: a row of slot cells with an output register.
//
//  channel   dir  fields (low bit up)
//  s_axis    in   tdata: signal_number[3:0], blocked_mask[19:4]; tuser: command
//  m_axis    out  tdata: taken_signal[4:0], accepted[5], occupancy[11:6]
//
// Each beat is handled in the cycle it is accepted: one item per cycle while the output side is not stalled.
// The first-unblocked search ripples through the row of cells, oldest first,
// and the same edge shifts the younger entries down over the removed one.
// The result waits in an output register; a new beat is taken whenever that
// register is empty or is being read in the same cycle.
// Reset clears the entry count and the output valid; slot contents need none.
module masked_pending_signal_queue_unit
    import mpsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // signal_number[3:0], blocked_mask[19:4], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // taken_signal[4:0], accepted[5], occupancy[11:6], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic                  in_fire;
    logic                  is_insert;
    logic                  is_take;
    logic                  full;
    logic [SIG_W-1:0]      in_sig;
    logic [MASK_W-1:0]     in_mask;

    t_chain                chain [QUEUE_DEPTH+1];
    logic [SIG_W-1:0]      cell_sig [QUEUE_DEPTH];

    // Beat decode.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign is_insert = in_fire && (s_axis_tuser == CMD_INSERT);
    assign is_take   = in_fire && (s_axis_tuser == CMD_TAKE);
    assign full      = (r_count == CW'(QUEUE_DEPTH));
    assign in_sig    = s_axis_tdata[SIG_W-1:0];
    assign in_mask   = s_axis_tdata[SIG_W+MASK_W-1:SIG_W];

    // Row of slot cells; the search enters at the oldest slot.
    assign chain[0] = '{found: 1'b0, sig: '0};

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        t_cell_ctl        ctl;
        logic [SIG_W-1:0] next_sig;

        always_comb begin
            ctl.occupied = (CW'(i) < r_count);
            ctl.load     = is_insert && !full && (r_count == CW'(i));
            ctl.take     = is_take;
        end

        if (i + 1 < QUEUE_DEPTH) begin : g_mid
            assign next_sig = cell_sig[i+1];
        end else begin : g_last
            assign next_sig = cell_sig[i];
        end

        mpsq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_mask     (in_mask),
            .i_ins_sig  (in_sig),
            .i_next_sig (next_sig),
            .i_chain    (chain[i]),
            .o_chain    (chain[i+1]),
            .o_sig      (cell_sig[i])
        );
    end

    // Next count and the result beat.
    always_comb begin
        logic [TAKEN_W-1:0] taken;
        logic               accepted;
        n_count  = r_count;
        taken    = NO_SIGNAL;
        accepted = 1'b1;
        if (is_insert) begin
            if (full) begin
                accepted = 1'b0;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (is_take && chain[QUEUE_DEPTH].found) begin
            taken   = TAKEN_W'(chain[QUEUE_DEPTH].sig);
            n_count = r_count - CW'(1);
        end
        n_out_data = {4'b0000, OCC_W'(n_count), accepted, taken};
    end

    // Count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The count never passes the queue depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // An insert into a queue with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_insert && !full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    // A take that finds nothing leaves the count alone.
    a_take_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_take && !chain[QUEUE_DEPTH].found) |=> (r_count == $past(r_count)))
        else $error("unsuccessful take changed the count");

endmodule

FILE: dv/masked_pending_signal_queue_unit_tb.sv
// Self-checking testbench for the masked pending signal queue, with its own queue predictor.
`timescale 1ns / 100ps

module masked_pending_signal_queue_unit_tb;
    import mpsq_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int RAND_ITEMS  = 600;
    localparam int CALM_ITEMS  = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // One command beat as the predictor sees it.
    typedef struct {
        logic              cmd;
        logic [SIG_W-1:0]  sig;
        logic [MASK_W-1:0] mask;
    } t_sig_cmd;

    // One result beat, field by field.
    typedef struct {
        logic [TAKEN_W-1:0] taken;
        logic               accepted;
        logic [OCC_W-1:0]   occ;
    } t_take_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // signal_number[3:0], blocked_mask[19:4], zero pad
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    // command
    logic s_axis_tuser = CMD_INSERT;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // taken_signal[4:0], accepted[5], occupancy[11:6], zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_sig_cmd     cmd_backlog[$];
    t_sig_cmd     cmd_on_bus;
    t_take_result expected_results[$];
    logic [SIG_W-1:0] pending_sigs[$];
    int src_idle_left = 0;
    int snk_stall_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    masked_pending_signal_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Free-running clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one command to the predicted queue and return the result it should give.
    function automatic t_take_result predict_pending(t_sig_cmd item);
        t_take_result res;
        int pos;
        res.taken = NO_SIGNAL;
        res.accepted = 1'b1;
        pos = -1;
        if (item.cmd == CMD_INSERT) begin
            if (pending_sigs.size() < DEPTH) begin
                pending_sigs.push_back(item.sig);
            end else begin
                res.accepted = 1'b0;
            end
        end else begin
            for (int i = 0; i < pending_sigs.size() && pos < 0; i++) begin
                if (!item.mask[pending_sigs[i]]) begin
                    pos = i;
                end
            end
            if (pos >= 0) begin
                res.taken = {1'b0, pending_sigs[pos]};
                pending_sigs.delete(pos);
            end
        end
        res.occ = OCC_W'(pending_sigs.size());
        return res;
    endfunction

    function automatic void report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endfunction

    function automatic void add_insert(logic [SIG_W-1:0] sig);
        t_sig_cmd item;
        item.cmd = CMD_INSERT;
        item.sig = sig;
        item.mask = MASK_W'($urandom);
        cmd_backlog.push_back(item);
    endfunction

    function automatic void add_take(logic [MASK_W-1:0] mask);
        t_sig_cmd item;
        item.cmd = CMD_TAKE;
        item.sig = SIG_W'($urandom);
        item.mask = mask;
        cmd_backlog.push_back(item);
    endfunction

    // Masks range from nothing blocked to everything blocked, with dense and sparse mixes.
    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = '1;
            2: m = MASK_W'($urandom);
            3: m = ~(MASK_W'(1) << $urandom_range(0, 15));
            4: m = MASK_W'($urandom & $urandom);
            default: m = MASK_W'($urandom | $urandom);
        endcase
        return m;
    endfunction

    // Source side: send queued command beats, with idle bursts except near the end.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expected_results.push_back(predict_pending(cmd_on_bus));
            end
            if (src_idle_left > 0) begin
                src_idle_left--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_backlog.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                src_idle_left = $urandom_range(1, 19) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                cmd_on_bus = cmd_backlog.pop_front();
                s_axis_tdata <= {{(IN_DATA_W - SIG_W - MASK_W){1'b0}},
                                 cmd_on_bus.mask, cmd_on_bus.sig};
                s_axis_tuser <= cmd_on_bus.cmd;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check each result beat against the oldest expectation, stalling in bursts.
    always @(posedge i_clk) begin
        t_take_result got;
        t_take_result exp_res;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.taken = m_axis_tdata[4:0];
                got.accepted = m_axis_tdata[5];
                got.occ = m_axis_tdata[11:6];
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result taken=%0d accepted=%0d occ=%0d",
                                              got.taken, got.accepted, got.occ));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.taken !== exp_res.taken) begin
                        report_mismatch($sformatf("taken_signal expected %0d, got %0d",
                                                  exp_res.taken, got.taken));
                    end
                    if (got.accepted !== exp_res.accepted) begin
                        report_mismatch($sformatf("accepted expected %0d, got %0d",
                                                  exp_res.accepted, got.accepted));
                    end
                    if (got.occ !== exp_res.occ) begin
                        report_mismatch($sformatf("occupancy expected %0d, got %0d",
                                                  exp_res.occ, got.occ));
                    end
                end
            end
            if (snk_stall_left > 0) begin
                snk_stall_left--;
                m_axis_tready <= 1'b0;
            end else if (cmd_backlog.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                snk_stall_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int sent;
        int phase_len;
        int insert_pct;

        // Directed: empty take, extreme signals, duplicates, all blocked, mid-queue removal.
        add_take('0);
        add_insert(4'd0);
        add_insert(4'd15);
        add_insert(4'd5);
        add_insert(4'd15);
        add_insert(4'd0);
        add_take('1);
        add_take(16'h0001);
        add_take(~16'h0020);
        add_take(16'h8000);
        add_take('0);
        add_take('0);
        add_take('0);
        add_take('0);

        // Random phases that lean toward filling or draining, so full and empty both occur.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            phase_len = $urandom_range(10, 70);
            case ($urandom_range(0, 4))
                0: insert_pct = 90;
                1: insert_pct = 70;
                2: insert_pct = 50;
                3: insert_pct = 30;
                default: insert_pct = 10;
            endcase
            for (int k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
                if ($urandom_range(1, 100) <= insert_pct) begin
                    add_insert(SIG_W'($urandom));
                end else begin
                    add_take(random_mask());
                end
                sent++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((cmd_backlog.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
               && cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            mismatch_count++;
        end
        if (expected_results.size() > 0) begin
            $display("%0d expected results never arrived.", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("masked_pending_signal_queue_unit_tb: done, clean");
        end else begin
            $display("masked_pending_signal_queue_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
